// File: hdl/telemetry_frame_builder_crc16_assert.svh
// Assertion macros for the telemetry frame builder.
`ifndef TELEMETRY_FRAME_BUILDER_CRC16_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_CRC16_ASSERT_SVH

`ifndef SYNTHESIS
`define TFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("telemetry frame builder: assertion failed");
`define TFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("telemetry frame builder: assertion failed");
`else
`define TFB_ASSERT_NOW(lbl, ante, cons)
`define TFB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/tfb_pkg.sv
// Shared types and constants of the telemetry frame builder.
package tfb_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int INPUT_SLOTS = 8;
  localparam int SLOTS_USED  = (SLOT_COUNT < INPUT_SLOTS) ? SLOT_COUNT : INPUT_SLOTS;
  localparam int SERIAL_WRAP = 60000;
  localparam int FORCED_SLOT = 2;

  localparam int REC_COUNT = SLOTS_USED + 2;
  localparam int REC_W     = $clog2(REC_COUNT);
  localparam int SLOT_W    = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [7:0] HEADER_BYTE  = 8'h5A;
  localparam logic [7:0] TRAILER_BYTE = 8'hA5;
  localparam logic [7:0] ALARM_TAG    = 8'h02;
  localparam logic [7:0] STATE_TAG    = 8'h11;
  localparam logic [7:0] LEN_BASE     = 8'd2;

  localparam logic [16:0] SERIAL_WRAP_V = 17'(SERIAL_WRAP);

  localparam logic [REC_W-1:0] REC_ALARM      = REC_W'(0);
  localparam logic [REC_W-1:0] REC_STATE      = REC_W'(1);
  localparam logic [REC_W-1:0] REC_FIRST_SLOT = REC_W'(2);
  localparam logic [REC_W-1:0] REC_LAST       = REC_W'(REC_COUNT - 1);

  localparam logic [REG_IDX_W-1:0] REG_MASK  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_STOP  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_START = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ALARM = REG_IDX_W'(3);

  localparam logic [7:0]  MASK_RESET  = 8'd15;
  localparam logic [15:0] STOP_RESET  = 16'd0;
  localparam logic [15:0] START_RESET = 16'd1;
  localparam logic [15:0] ALARM_RESET = 16'd2;

  typedef struct packed {
    logic [15:0] alarm_word;
    logic [15:0] state_code;
    logic [15:0] slot_value_0;
    logic [15:0] slot_value_1;
    logic [15:0] slot_value_2;
    logic [15:0] slot_value_3;
    logic [15:0] slot_value_4;
    logic [15:0] slot_value_5;
    logic [15:0] slot_value_6;
    logic [15:0] slot_value_7;
  } tfb_snap_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } tfb_tx_t;

  typedef struct packed {
    logic [7:0]  slot_enable_mask;
    logic [15:0] stop_state_code;
    logic [15:0] start_state_code;
    logic [15:0] alarm_state_code;
  } tfb_cfg_t;

  typedef struct packed {
    logic       clear;
    logic       update;
    logic [7:0] data;
  } tfb_crc_ctrl_t;

  typedef enum logic [1:0] {
    PART_TAG,
    PART_HI,
    PART_LO
  } tfb_part_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_LEN,
    ST_SER_HI,
    ST_SER_LO,
    ST_REC,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_TRL0,
    ST_TRL1
  } tfb_state_t;

endpackage

// File: hdl/tfb_regs.sv
// APB configuration registers of the telemetry frame builder.
module tfb_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tfb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tfb_pkg::tfb_cfg_t         cfg
);

  logic [tfb_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign pready = 1'b1;
  assign idx    = paddr[tfb_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_enable_mask <= tfb_pkg::MASK_RESET;
      cfg.stop_state_code  <= tfb_pkg::STOP_RESET;
      cfg.start_state_code <= tfb_pkg::START_RESET;
      cfg.alarm_state_code <= tfb_pkg::ALARM_RESET;
    end else if (wr) begin
      unique case (idx)
        tfb_pkg::REG_MASK:  cfg.slot_enable_mask <= pwdata[7:0];
        tfb_pkg::REG_STOP:  cfg.stop_state_code  <= pwdata[15:0];
        tfb_pkg::REG_START: cfg.start_state_code <= pwdata[15:0];
        tfb_pkg::REG_ALARM: cfg.alarm_state_code <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tfb_pkg::REG_MASK:  prdata = {24'd0, cfg.slot_enable_mask};
      tfb_pkg::REG_STOP:  prdata = {16'd0, cfg.stop_state_code};
      tfb_pkg::REG_START: prdata = {16'd0, cfg.start_state_code};
      tfb_pkg::REG_ALARM: prdata = {16'd0, cfg.alarm_state_code};
    endcase
  end

endmodule

// File: hdl/tfb_crc.sv
// Shared CRC-16/XMODEM unit, one byte per cycle.
module tfb_crc (
  input  logic                   clk,
  input  logic                   rst,
  input  tfb_pkg::tfb_crc_ctrl_t ctrl,
  output logic [15:0]            crc
);

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c[15:8] ^ b;
    x = x ^ {4'd0, x[7:4]};
    return {c[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      crc <= 16'd0;
    end else if (ctrl.update) begin
      crc <= crc_byte(crc, ctrl.data);
    end
  end

endmodule

// File: hdl/tfb_seq.sv
// Frame sequencer: latches a snapshot and walks the frame one byte at a time.
module tfb_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_valid,
  output logic                   snap_stall,
  input  tfb_pkg::tfb_snap_t     snap,
  output logic                   tx_valid,
  input  logic                   tx_stall,
  output tfb_pkg::tfb_tx_t       tx,
  input  tfb_pkg::tfb_cfg_t      cfg,
  input  logic [15:0]            crc,
  output tfb_pkg::tfb_crc_ctrl_t crc_ctrl
);

  tfb_pkg::tfb_state_t state, state_next;
  tfb_pkg::tfb_part_t  part;
  logic [tfb_pkg::REC_W-1:0] rec_idx;

  logic [15:0] serial_counter;
  logic [15:0] previous_state_code;
  logic [15:0] serial_tx;
  logic [15:0] alarm_l;
  logic [15:0] state_l;
  logic [7:0]  mask_l;
  logic [7:0]  len_l;
  logic [15:0] slot_val [tfb_pkg::SLOTS_USED];

  logic [15:0] in_slots [tfb_pkg::INPUT_SLOTS];
  logic        accept;
  logic        can_emit;
  logic        emit;
  logic        step;
  tfb_pkg::tfb_tx_t tx_next;

  logic        restart;
  logic        force_zero;
  logic [15:0] serial_now;
  logic [16:0] serial_inc;
  logic [7:0]  count;

  logic [tfb_pkg::REC_W-1:0]  rec_off;
  logic [tfb_pkg::SLOT_W-1:0] slot;
  logic        rec_on;
  logic [7:0]  rec_tag;
  logic [15:0] rec_val;
  logic [7:0]  rec_byte;

  assign snap_stall = (state != tfb_pkg::ST_IDLE);
  assign accept     = snap_valid && !snap_stall;
  assign can_emit   = !tx_valid || !tx_stall;

  assign in_slots[0] = snap.slot_value_0;
  assign in_slots[1] = snap.slot_value_1;
  assign in_slots[2] = snap.slot_value_2;
  assign in_slots[3] = snap.slot_value_3;
  assign in_slots[4] = snap.slot_value_4;
  assign in_slots[5] = snap.slot_value_5;
  assign in_slots[6] = snap.slot_value_6;
  assign in_slots[7] = snap.slot_value_7;

  // serial restart on stop-to-start, wrap past the limit
  assign restart    = (snap.state_code == cfg.start_state_code) &&
                      (previous_state_code == cfg.stop_state_code);
  assign force_zero = (snap.state_code == cfg.stop_state_code) ||
                      (snap.state_code == cfg.alarm_state_code);
  assign serial_now = restart ? 16'd0 : serial_counter;
  assign serial_inc = {1'b0, serial_now} + 17'd1;

  always_comb begin
    count = 8'd0;
    for (int i = 0; i < tfb_pkg::SLOTS_USED; i++) begin
      count = count + {7'd0, cfg.slot_enable_mask[i]};
    end
  end

  // current record
  assign rec_off = rec_idx - tfb_pkg::REC_FIRST_SLOT;
  assign slot    = rec_off[tfb_pkg::SLOT_W-1:0];

  always_comb begin
    rec_on = (rec_idx < tfb_pkg::REC_FIRST_SLOT) || mask_l[slot];
    if (rec_idx == tfb_pkg::REC_ALARM) begin
      rec_tag = tfb_pkg::ALARM_TAG;
      rec_val = alarm_l;
    end else if (rec_idx == tfb_pkg::REC_STATE) begin
      rec_tag = tfb_pkg::STATE_TAG;
      rec_val = state_l;
    end else begin
      rec_tag = 8'(slot);
      rec_val = slot_val[slot];
    end
    unique case (part)
      tfb_pkg::PART_TAG: rec_byte = rec_tag;
      tfb_pkg::PART_HI:  rec_byte = rec_val[15:8];
      tfb_pkg::PART_LO:  rec_byte = rec_val[7:0];
      default:           rec_byte = rec_tag;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tfb_pkg::ST_IDLE:   if (accept)   state_next = tfb_pkg::ST_HDR0;
      tfb_pkg::ST_HDR0:   if (can_emit) state_next = tfb_pkg::ST_HDR1;
      tfb_pkg::ST_HDR1:   if (can_emit) state_next = tfb_pkg::ST_LEN;
      tfb_pkg::ST_LEN:    if (can_emit) state_next = tfb_pkg::ST_SER_HI;
      tfb_pkg::ST_SER_HI: if (can_emit) state_next = tfb_pkg::ST_SER_LO;
      tfb_pkg::ST_SER_LO: if (can_emit) state_next = tfb_pkg::ST_REC;
      tfb_pkg::ST_REC: begin
        if (step && rec_idx == tfb_pkg::REC_LAST) state_next = tfb_pkg::ST_CRC_HI;
      end
      tfb_pkg::ST_CRC_HI: if (can_emit) state_next = tfb_pkg::ST_CRC_LO;
      tfb_pkg::ST_CRC_LO: if (can_emit) state_next = tfb_pkg::ST_TRL0;
      tfb_pkg::ST_TRL0:   if (can_emit) state_next = tfb_pkg::ST_TRL1;
      tfb_pkg::ST_TRL1:   if (can_emit) state_next = tfb_pkg::ST_IDLE;
      default:            state_next = tfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit            = 1'b0;
    step            = 1'b0;
    tx_next         = '0;
    crc_ctrl.clear  = accept;
    crc_ctrl.update = 1'b0;
    crc_ctrl.data   = rec_byte;
    unique case (state)
      tfb_pkg::ST_IDLE: begin
      end
      tfb_pkg::ST_HDR0, tfb_pkg::ST_HDR1: begin
        emit            = can_emit;
        tx_next.tx_byte = tfb_pkg::HEADER_BYTE;
      end
      tfb_pkg::ST_LEN: begin
        emit            = can_emit;
        tx_next.tx_byte = len_l;
      end
      tfb_pkg::ST_SER_HI: begin
        emit            = can_emit;
        tx_next.tx_byte = serial_tx[15:8];
      end
      tfb_pkg::ST_SER_LO: begin
        emit            = can_emit;
        tx_next.tx_byte = serial_tx[7:0];
      end
      tfb_pkg::ST_REC: begin
        tx_next.tx_byte = rec_byte;
        if (!rec_on) begin
          step = 1'b1;
        end else begin
          emit            = can_emit;
          crc_ctrl.update = can_emit;
          step            = can_emit && (part == tfb_pkg::PART_LO);
        end
      end
      tfb_pkg::ST_CRC_HI: begin
        emit            = can_emit;
        tx_next.tx_byte = crc[15:8];
      end
      tfb_pkg::ST_CRC_LO: begin
        emit            = can_emit;
        tx_next.tx_byte = crc[7:0];
      end
      tfb_pkg::ST_TRL0: begin
        emit            = can_emit;
        tx_next.tx_byte = tfb_pkg::TRAILER_BYTE;
      end
      tfb_pkg::ST_TRL1: begin
        emit              = can_emit;
        tx_next.tx_byte   = tfb_pkg::TRAILER_BYTE;
        tx_next.frame_end = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= tfb_pkg::ST_IDLE;
      tx_valid            <= 1'b0;
      rec_idx             <= tfb_pkg::REC_ALARM;
      part                <= tfb_pkg::PART_TAG;
      serial_counter      <= 16'd0;
      previous_state_code <= 16'd0;
    end else begin
      state <= state_next;
      if (emit) begin
        tx_valid <= 1'b1;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
      if (accept) begin
        rec_idx             <= tfb_pkg::REC_ALARM;
        part                <= tfb_pkg::PART_TAG;
        previous_state_code <= snap.state_code;
        serial_counter      <= (serial_inc > tfb_pkg::SERIAL_WRAP_V) ? 16'd0
                                                                     : serial_inc[15:0];
      end else if (step) begin
        rec_idx <= rec_idx + tfb_pkg::REC_W'(1);
        part    <= tfb_pkg::PART_TAG;
      end else if (emit && state == tfb_pkg::ST_REC) begin
        part <= (part == tfb_pkg::PART_TAG) ? tfb_pkg::PART_HI : tfb_pkg::PART_LO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx <= tx_next;
    end
    if (accept) begin
      serial_tx <= serial_now;
      alarm_l   <= snap.alarm_word;
      state_l   <= snap.state_code;
      mask_l    <= cfg.slot_enable_mask;
      len_l     <= tfb_pkg::LEN_BASE + count;
      for (int i = 0; i < tfb_pkg::SLOTS_USED; i++) begin
        slot_val[i] <= (i == tfb_pkg::FORCED_SLOT && force_zero) ? 16'd0 : in_slots[i];
      end
    end
  end

endmodule

// File: hdl/telemetry_frame_builder_crc16.sv
// Top level of the telemetry frame builder with CRC-16/XMODEM.
//
// One snapshot request in, one serial frame out, one byte per request on the
// tx channel: 5A 5A, length, serial, alarm and state records, the enabled slot
// records, CRC-16/XMODEM over the records, A5 A5. The snapshot port stalls
// while a frame is being built. With n enabled slots a frame is 15 + 3n bytes.
// The sequencer moves one byte per cycle while tx does not stall, feeds the
// record bytes through the CRC unit and steps over each disabled slot without
// emitting a byte. The last byte may still wait in the output register while
// the next snapshot is taken. Configuration goes through the APB port; the
// user must write it only while idle, the block itself does not enforce it.
`include "telemetry_frame_builder_crc16_assert.svh"

module telemetry_frame_builder_crc16 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       snap_valid,
  output logic                       snap_stall,
  input  tfb_pkg::tfb_snap_t         snap,
  output logic                       tx_valid,
  input  logic                       tx_stall,
  output tfb_pkg::tfb_tx_t           tx
);

  tfb_pkg::tfb_cfg_t      cfg;
  tfb_pkg::tfb_crc_ctrl_t crc_ctrl;
  logic [15:0]            crc_value;

  tfb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfb_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc_value)
  );

  tfb_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx         (tx),
    .cfg        (cfg),
    .crc        (crc_value),
    .crc_ctrl   (crc_ctrl)
  );

  `TFB_ASSERT_NEXT(a_busy_after_request, snap_valid && !snap_stall, snap_stall)
  `TFB_ASSERT_NEXT(a_crc_cleared, snap_valid && !snap_stall, crc_value == 16'd0)
  `TFB_ASSERT_NOW(a_end_is_trailer, tx_valid && tx.frame_end, tx.tx_byte == tfb_pkg::TRAILER_BYTE)

endmodule

// File: bench/telemetry_frame_builder_crc16_tb.sv
// Self-checking testbench for the telemetry frame builder: frames checked byte by byte.
`timescale 1ns / 1ps

module telemetry_frame_builder_crc16_tb;

  localparam int          CYCLE_LIMIT = 10_000_000;
  localparam int          NUM_SLOTS   = 8;
  localparam int          WRAP_AT     = 60000;
  localparam logic [7:0]  SYNC_BYTE   = 8'h5A;
  localparam logic [7:0]  TAIL_BYTE   = 8'hA5;
  localparam logic [7:0]  TAG_ALARM   = 8'h02;
  localparam logic [7:0]  TAG_STATE   = 8'h11;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef logic [tfb_pkg::REG_IDX_W-1:0] reg_idx_t;

  typedef struct {
    bit                 wr;
    reg_idx_t           idx;
    logic [31:0]        val;
    tfb_pkg::tfb_snap_t s;
    bit                 typed;
    logic [7:0]         len;
    logic [15:0]        serial;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tfb_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       snap_valid = 1'b0;
  logic                       snap_stall;
  tfb_pkg::tfb_snap_t         snap_d = '0;
  logic                       tx_valid;
  logic                       tx_stall = 1'b0;
  tfb_pkg::tfb_tx_t           tx_d;

  // predictor copy of registers and state
  logic [7:0]  cfg_mask;
  logic [15:0] cfg_stop;
  logic [15:0] cfg_start;
  logic [15:0] cfg_alarm;
  logic [15:0] serial_nr;
  logic [15:0] prev_code;

  tfb_pkg::tfb_tx_t frame_bytes[$];
  plan_row_t        plan[$];
  int               fail_count = 0;
  int               cycles = 0;
  int               stall_left = 0;
  bit               rx_quiet = 1'b0;

  telemetry_frame_builder_crc16 DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .snap_valid(snap_valid),
    .snap_stall(snap_stall),
    .snap      (snap_d),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx        (tx_d)
  );

  always #4 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic logic [15:0] rnd16();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic tfb_pkg::tfb_snap_t pattern(logic [15:0] alarm, logic [15:0] state,
                                                 logic [15:0] base, logic [15:0] step);
    tfb_pkg::tfb_snap_t s;
    s.alarm_word   = alarm;
    s.state_code   = state;
    s.slot_value_0 = base;
    s.slot_value_1 = base + step;
    s.slot_value_2 = base + 16'(2) * step;
    s.slot_value_3 = base + 16'(3) * step;
    s.slot_value_4 = base + 16'(4) * step;
    s.slot_value_5 = base + 16'(5) * step;
    s.slot_value_6 = base + 16'(6) * step;
    s.slot_value_7 = base + 16'(7) * step;
    return s;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_t idx, logic [31:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.wr  = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t snap_row(tfb_pkg::tfb_snap_t s, logic [7:0] len,
                                         logic [15:0] serial);
    plan_row_t r;
    r = '{default: '0};
    r.s      = s;
    r.typed  = 1'b1;
    r.len    = len;
    r.serial = serial;
    return r;
  endfunction

  function automatic void add_record(ref tfb_pkg::tfb_tx_t f[$], ref logic [15:0] crc,
                                     input logic [7:0] tag, input logic [15:0] val);
    logic [7:0] b [3];
    b[0] = tag;
    b[1] = val[15:8];
    b[2] = val[7:0];
    for (int k = 0; k < 3; k++) begin
      f.push_back('{tx_byte: b[k], frame_end: 1'b0});
      crc = crc ^ {b[k], 8'h00};
      for (int j = 0; j < 8; j++)
        crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
  endfunction

  // Works out the frame for one accepted snapshot; typed rows override
  // the length and serial bytes with the values from the plan.
  task automatic build_frame(input tfb_pkg::tfb_snap_t s, input bit typed,
                             input logic [7:0] t_len, input logic [15:0] t_serial);
    tfb_pkg::tfb_tx_t f[$];
    logic [15:0]      raw [NUM_SLOTS];
    logic [15:0]      crc;
    logic [16:0]      nxt;
    logic [7:0]       n_on;
    raw[0] = s.slot_value_0;
    raw[1] = s.slot_value_1;
    raw[2] = s.slot_value_2;
    raw[3] = s.slot_value_3;
    raw[4] = s.slot_value_4;
    raw[5] = s.slot_value_5;
    raw[6] = s.slot_value_6;
    raw[7] = s.slot_value_7;
    crc  = 16'h0000;
    n_on = 8'd0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (cfg_mask[i]) n_on++;
    if (s.state_code == cfg_start && prev_code == cfg_stop) serial_nr = 16'h0000;
    prev_code = s.state_code;
    f.push_back('{tx_byte: SYNC_BYTE, frame_end: 1'b0});
    f.push_back('{tx_byte: SYNC_BYTE, frame_end: 1'b0});
    f.push_back('{tx_byte: 8'd2 + n_on, frame_end: 1'b0});
    f.push_back('{tx_byte: serial_nr[15:8], frame_end: 1'b0});
    f.push_back('{tx_byte: serial_nr[7:0], frame_end: 1'b0});
    nxt = {1'b0, serial_nr} + 17'd1;
    if (nxt > 17'(WRAP_AT)) nxt = '0;
    serial_nr = nxt[15:0];
    add_record(f, crc, TAG_ALARM, s.alarm_word);
    add_record(f, crc, TAG_STATE, s.state_code);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cfg_mask[i]) begin
        if (i == 2 && (s.state_code == cfg_stop || s.state_code == cfg_alarm))
          add_record(f, crc, 8'(i), 16'h0000);
        else
          add_record(f, crc, 8'(i), raw[i]);
      end
    end
    f.push_back('{tx_byte: crc[15:8], frame_end: 1'b0});
    f.push_back('{tx_byte: crc[7:0], frame_end: 1'b0});
    f.push_back('{tx_byte: TAIL_BYTE, frame_end: 1'b0});
    f.push_back('{tx_byte: TAIL_BYTE, frame_end: 1'b1});
    if (typed) begin
      f[2].tx_byte = t_len;
      f[3].tx_byte = t_serial[15:8];
      f[4].tx_byte = t_serial[7:0];
    end
    foreach (f[i]) frame_bytes.push_back(f[i]);
  endtask

  task automatic send_snap(input tfb_pkg::tfb_snap_t s, input int gap, input bit typed,
                           input logic [7:0] t_len, input logic [15:0] t_serial);
    @(negedge clk);
    if (gap > 0) begin
      snap_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    snap_valid = 1'b1;
    snap_d     = s;
    do @(posedge clk); while (snap_stall);
    build_frame(s, typed, t_len, t_serial);
  endtask

  // Register write while idle, followed by a read back of the same register.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rd;
    logic        ok;
    @(negedge clk);
    snap_valid = 1'b0;
    wait (frame_bytes.size() == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel       = 1'b1;
    penable    = 1'b0;
    pwrite     = 1'b1;
    paddr      = tfb_pkg::ADDR_W'({idx, 2'b00});
    pwdata     = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      tfb_pkg::REG_MASK: begin
        cfg_mask = val[7:0];
        ok = (rd[7:0] === cfg_mask);
      end
      tfb_pkg::REG_STOP: begin
        cfg_stop = val[15:0];
        ok = (rd[15:0] === cfg_stop);
      end
      tfb_pkg::REG_START: begin
        cfg_start = val[15:0];
        ok = (rd[15:0] === cfg_start);
      end
      default: begin
        cfg_alarm = val[15:0];
        ok = (rd[15:0] === cfg_alarm);
      end
    endcase
    if (!ok) begin
      $error("prdata reg %0d: expected %h, got %h", idx, val, rd);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    if (rst || rx_quiet) begin
      tx_stall   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      tx_stall   <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      tx_stall   <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      tx_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tfb_pkg::tfb_tx_t want;
    if (!rst && tx_valid && !tx_stall) begin
      if (frame_bytes.size() == 0) begin
        $error("tx request with nothing pending: tx_byte %h frame_end %b",
               tx_d.tx_byte, tx_d.frame_end);
        fail_count++;
      end else begin
        want = frame_bytes.pop_front();
        if (tx_d.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, tx_d.tx_byte);
          fail_count++;
        end
        if (tx_d.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, tx_d.frame_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    tfb_pkg::tfb_snap_t s;
    logic [15:0]        st;
    int                 pick;
    cfg_mask   = 8'd15;
    cfg_stop   = 16'd0;
    cfg_start  = 16'd1;
    cfg_alarm  = 16'd2;
    serial_nr  = 16'd0;
    prev_code  = 16'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: length and serial read straight off the frame layout
    plan.push_back(snap_row(pattern(16'h0000, 16'h0001, 16'h0000, 16'h0000), 8'd6, 16'd0));
    plan.push_back(snap_row(pattern(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000), 8'd6, 16'd1));
    plan.push_back(snap_row(pattern(16'h1234, 16'h0000, 16'hFFFF, 16'h0000), 8'd6, 16'd2));
    plan.push_back(snap_row(pattern(16'h8001, 16'h0002, 16'h5555, 16'h0000), 8'd6, 16'd3));
    plan.push_back(snap_row(pattern(16'h7FFE, 16'h0001, 16'hAAAA, 16'h0000), 8'd6, 16'd4));
    plan.push_back(snap_row(pattern(16'h0F0F, 16'h0000, 16'h0102, 16'h1111), 8'd6, 16'd5));
    plan.push_back(snap_row(pattern(16'hF0F0, 16'h0001, 16'h0102, 16'h1111), 8'd6, 16'd0));
    plan.push_back(snap_row(pattern(16'hAAAA, 16'hFFFF, 16'hAAAA, 16'h0000), 8'd6, 16'd1));
    plan.push_back(cfg_row(tfb_pkg::REG_MASK, 32'h0000_00FF));
    plan.push_back(snap_row(pattern(16'h5555, 16'h1234, 16'h0102, 16'h1111), 8'd10, 16'd2));
    plan.push_back(snap_row(pattern(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000), 8'd10, 16'd3));
    plan.push_back(cfg_row(tfb_pkg::REG_MASK, 32'h0000_0000));
    plan.push_back(snap_row(pattern(16'h0001, 16'h0001, 16'hFFFF, 16'h0000), 8'd2, 16'd0));
    plan.push_back(snap_row(pattern(16'hFFFF, 16'h0007, 16'h0000, 16'h0000), 8'd2, 16'd1));
    plan.push_back(cfg_row(tfb_pkg::REG_MASK, 32'h0000_0004));
    plan.push_back(cfg_row(tfb_pkg::REG_ALARM, 32'h0000_FFFF));
    plan.push_back(cfg_row(tfb_pkg::REG_STOP, 32'h0000_8000));
    plan.push_back(snap_row(pattern(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000), 8'd3, 16'd2));
    plan.push_back(snap_row(pattern(16'h0000, 16'h8000, 16'hFFFF, 16'h0000), 8'd3, 16'd3));
    plan.push_back(snap_row(pattern(16'h0000, 16'h0002, 16'hFFFF, 16'h0000), 8'd3, 16'd4));
    // start and stop codes equal: every repeat of the code restarts the serial
    plan.push_back(cfg_row(tfb_pkg::REG_START, 32'h0000_8000));
    plan.push_back(cfg_row(tfb_pkg::REG_MASK, 32'h0000_0080));
    plan.push_back(snap_row(pattern(16'h1111, 16'h8000, 16'hFFFF, 16'h0000), 8'd3, 16'd5));
    plan.push_back(snap_row(pattern(16'h2222, 16'h8000, 16'h8001, 16'h0000), 8'd3, 16'd0));
    plan.push_back(snap_row(pattern(16'h3333, 16'h8000, 16'h7FFF, 16'h0000), 8'd3, 16'd0));
    plan.push_back(snap_row(pattern(16'h4444, 16'h0001, 16'h0000, 16'h0000), 8'd3, 16'd1));
    plan.push_back(cfg_row(tfb_pkg::REG_MASK, 32'h0000_00FF));
    plan.push_back(cfg_row(tfb_pkg::REG_STOP, 32'h0000_0000));
    plan.push_back(cfg_row(tfb_pkg::REG_START, 32'h0000_0001));
    plan.push_back(cfg_row(tfb_pkg::REG_ALARM, 32'h0000_0002));
    plan.push_back(snap_row(pattern(16'h0000, 16'h0000, 16'h0000, 16'h0000), 8'd10, 16'd2));

    foreach (plan[i]) begin
      if (plan[i].wr) reg_write(plan[i].idx, plan[i].val);
      else send_snap(plan[i].s, gap_len(), 1'b1, plan[i].len, plan[i].serial);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(tfb_pkg::REG_MASK, 32'h0000_00FF);
          reg_write(tfb_pkg::REG_STOP, 32'h0000_0000);
          reg_write(tfb_pkg::REG_START, 32'h0000_FFFF);
          reg_write(tfb_pkg::REG_ALARM, 32'h0000_0001);
        end
        1: begin
          reg_write(tfb_pkg::REG_MASK, 32'h0000_0000);
          reg_write(tfb_pkg::REG_STOP, 32'h0000_FFFF);
          reg_write(tfb_pkg::REG_START, 32'h0000_0000);
          reg_write(tfb_pkg::REG_ALARM, 32'h0000_8000);
        end
        4: begin
          reg_write(tfb_pkg::REG_MASK, 32'($urandom_range(0, 255)));
          reg_write(tfb_pkg::REG_STOP, 32'(rnd16()));
          reg_write(tfb_pkg::REG_START, {16'h0000, cfg_stop});
          reg_write(tfb_pkg::REG_ALARM, 32'(rnd16()));
        end
        default: begin
          reg_write(tfb_pkg::REG_MASK, 32'($urandom_range(0, 255)));
          reg_write(tfb_pkg::REG_STOP, 32'(rnd16()));
          reg_write(tfb_pkg::REG_START, 32'(rnd16()));
          reg_write(tfb_pkg::REG_ALARM, 32'(rnd16()));
        end
      endcase
      rx_quiet = (ph == 3);
      for (int k = 0; k < 76; k++) begin
        if (ph == 2 && k == 40) begin
          @(negedge clk);
          snap_valid = 1'b0;
          wait (frame_bytes.size() == 0);
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) st = cfg_stop;
        else if (pick < 6) st = cfg_start;
        else if (pick == 6) st = cfg_alarm;
        else st = rnd16();
        s.alarm_word   = rnd16();
        s.state_code   = st;
        s.slot_value_0 = rnd16();
        s.slot_value_1 = rnd16();
        s.slot_value_2 = rnd16();
        s.slot_value_3 = rnd16();
        s.slot_value_4 = rnd16();
        s.slot_value_5 = rnd16();
        s.slot_value_6 = rnd16();
        s.slot_value_7 = rnd16();
        send_snap(s, (ph == 3) ? 0 : gap_len(), 1'b0, 8'd0, 16'd0);
      end
    end

    // serial restart from stop to start with every slot off
    reg_write(tfb_pkg::REG_MASK, 32'h0000_0000);
    reg_write(tfb_pkg::REG_STOP, 32'h0000_0000);
    reg_write(tfb_pkg::REG_START, 32'h0000_0001);
    reg_write(tfb_pkg::REG_ALARM, 32'h0000_0002);
    rx_quiet = 1'b1;
    send_snap(pattern(16'h0000, 16'h0000, 16'h0000, 16'h0000), 0, 1'b0, 8'd0, 16'd0);
    send_snap(pattern(16'h0000, 16'h0001, 16'h0000, 16'h0000), 0, 1'b1, 8'd2, 16'd0);

    @(negedge clk);
    snap_valid = 1'b0;
    wait (frame_bytes.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tfb_pkg.sv
hdl/tfb_regs.sv
hdl/tfb_crc.sv
hdl/tfb_seq.sv
hdl/telemetry_frame_builder_crc16.sv
bench/telemetry_frame_builder_crc16_tb.sv
